/* src/hqs_pkg.sv */
// Package for the histogram quantile and shortfall block.
// Holds command and register codes, shared widths, structs and helpers.
// Depends on nothing.
package hqs_pkg;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUANT = 2'd1;
    localparam logic [1:0] CMD_SHORT = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] REG_RANGE_LOW = 2'd0;
    localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
    localparam logic [1:0] REG_INV_WIDTH = 2'd2;

    localparam int CFG_AW    = 4;
    localparam int TGT_W     = 34;
    localparam int RES_BIN_W = 13;

    typedef struct packed {
        logic [31:0] range_low;
        logic [31:0] bin_width;
        logic [31:0] inv_width;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [63:0]      dividend;
        logic [TGT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

/* src/hqs_if.sv */
// Handshake interfaces for the input and result channels.
// Depends on hqs_pkg.
interface hqs_in_if import hqs_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] sample_price;
    logic [16:0] fraction;

    modport source (output valid, output cmd, output sample_price, output fraction,
                    input ready);
    modport sink (input valid, input cmd, input sample_price, input fraction,
                  output ready);
endinterface

interface hqs_out_if import hqs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [31:0]          result_price;
    logic [RES_BIN_W-1:0] result_bin;
    logic                 hist_empty;

    modport source (output valid, output result_price, output result_bin,
                    output hist_empty, input ready);
    modport sink (input valid, input result_price, input result_bin,
                  input hist_empty, output ready);
endinterface

/* src/hqs_cfg.sv */
// Configuration registers behind an APB-style port.
// Depends on hqs_pkg.
module hqs_cfg import hqs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_low <= 32'd25600;
            r_cfg.bin_width <= 32'd466;
            r_cfg.inv_width <= 32'd36002;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RANGE_LOW: r_cfg.range_low <= pwdata;
                REG_BIN_WIDTH: r_cfg.bin_width <= pwdata;
                REG_INV_WIDTH: r_cfg.inv_width <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RANGE_LOW: prdata = r_cfg.range_low;
            REG_BIN_WIDTH: prdata = r_cfg.bin_width;
            REG_INV_WIDTH: prdata = r_cfg.inv_width;
            default:       prdata = 32'd0;
        endcase
    end
endmodule

/* src/hqs_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on hqs_pkg.
module hqs_div import hqs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic             r_busy;
    logic [5:0]       r_step;
    logic [63:0]      r_dvd;
    logic [TGT_W-1:0] r_rem;
    logic             r_done;
    logic [TGT_W:0]   trial;
    logic             q_bit;

    assign trial = {r_rem, r_dvd[63]};
    assign q_bit = (trial >= {1'b0, i_req.divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_step == 6'd63);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 6'd0;
                r_dvd  <= i_req.dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= q_bit ? TGT_W'(trial - {1'b0, i_req.divisor}) : trial[TGT_W-1:0];
                r_dvd  <= {r_dvd[62:0], q_bit};
                r_step <= r_step + 6'd1;
                if (r_step == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;
endmodule

/* src/histogram_quantile_shortfall.sv */
// Top level: bin count memory, command sequencer and result register.
// Depends on hqs_pkg, hqs_if, hqs_cfg and hqs_div.
//
//   channel   direction  handshake      payload
//   in_ch     in         valid/ready    cmd, sample_price, fraction
//   out_ch    out        valid/ready    result_price, result_bin, hist_empty
//   apb       in         psel/penable   range_low, bin_width, inv_width
//
// An add runs as reciprocal multiply, memory read, then write back.
// A quantile query scans one bin at a time through the single memory read port; a shortfall
// query also multiplies and accumulates each bin, then divides the sum in the divider.
// After reset and after a clear the memory is swept to zero, with no word taken.
// A finished result waits in the output register while the next word is accepted.
module histogram_quantile_shortfall import hqs_pkg::*; #(
    parameter int NUM_BINS = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hqs_in_if.sink            in_ch,
    hqs_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int IW = $clog2(NUM_BINS);
    localparam int CW = 32 + IW;
    localparam logic [IW-1:0] LAST_BIN = IW'(NUM_BINS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ADD_IDX, ST_ADD_WR, ST_TGT, ST_RD, ST_EV,
        ST_MUL, ST_ACC, ST_DIV, ST_OUT
    } t_state;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    hqs_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(cfg)
    );

    hqs_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic [31:0] r_mem [NUM_BINS];
    logic [31:0] r_rdata;

    t_state               r_state;
    logic                 r_clr_busy;
    logic [IW-1:0]        r_clr_addr;
    logic [31:0]          r_cnt;
    logic                 r_low_f;
    logic                 r_high_f;
    logic                 r_is_sf;
    logic [63:0]          r_prod;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_b;
    logic [63:0]          r_oddw;
    logic [CW-1:0]        r_cum;
    logic [TGT_W-1:0]     r_tgt;
    logic [TGT_W-1:0]     r_taken;
    logic [63:0]          r_sum;
    logic [31:0]          r_take;
    logic [31:0]          r_ctr;
    logic                 r_div_start;
    logic                 r_ov;
    logic [31:0]          r_res_price;
    logic [RES_BIN_W-1:0] r_res_bin;
    logic                 r_res_empty;
    logic [31:0]          r_o_price;
    logic [RES_BIN_W-1:0] r_o_bin;
    logic                 r_o_empty;

    logic             in_acc;
    logic             out_load;
    logic [31:0]      off;
    logic [63:0]      span;
    logic [IW-1:0]    idx_c;
    logic [IW-1:0]    raddr;
    logic             mem_we;
    logic [IW-1:0]    waddr;
    logic [31:0]      wdata;
    logic [32:0]      tgt_c;
    logic [31:0]      ctr_c;
    logic [CW-1:0]    cum_n;
    logic [TGT_W-1:0] rem_c;
    logic [31:0]      take_c;
    logic [64:0]      sum_n;

    assign in_ch.ready = (r_state == ST_IDLE) && !r_clr_busy;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_load    = (r_state == ST_OUT) && (!r_ov || out_ch.ready);

    assign off  = in_ch.sample_price - cfg.range_low;
    assign span = 64'(NUM_BINS) * {32'd0, cfg.bin_width};

    always_comb begin
        if (r_low_f) begin
            idx_c = '0;
        end else if (r_high_f || (r_prod[63:24] >= 40'(NUM_BINS))) begin
            idx_c = LAST_BIN;
        end else begin
            idx_c = r_prod[24+IW-1:24];
        end
    end

    assign raddr  = (r_state == ST_ADD_IDX) ? idx_c : r_b;
    assign mem_we = r_clr_busy || (r_state == ST_ADD_WR);
    assign waddr  = r_clr_busy ? r_clr_addr : r_idx;
    assign wdata  = r_clr_busy ? 32'd0 :
                    ((r_rdata == 32'hFFFF_FFFF) ? r_rdata : r_rdata + 32'd1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    assign tgt_c  = 33'((r_prod[48:0] + 49'd65535) >> 16);
    assign ctr_c  = sat32({32'd0, cfg.range_low} + (r_oddw >> 1));
    assign cum_n  = r_cum + CW'(r_rdata);
    assign rem_c  = r_tgt - r_taken;
    assign take_c = ({2'b0, r_rdata} > rem_c) ? rem_c[31:0] : r_rdata;
    assign sum_n  = {1'b0, r_sum} + {1'b0, r_prod};

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_sum;
    assign div_req.divisor  = r_taken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_cnt       <= 32'd0;
            r_ov        <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (out_ch.ready) begin
                r_ov <= 1'b0;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_BIN) begin
                    r_clr_busy <= 1'b0;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_is_sf <= (in_ch.cmd == CMD_SHORT);
                        unique case (in_ch.cmd)
                            CMD_ADD: begin
                                r_low_f  <= (in_ch.sample_price <= cfg.range_low);
                                r_high_f <= ({32'd0, off} >= span);
                                r_prod   <= {32'd0, off} * {32'd0, cfg.inv_width};
                                r_state  <= ST_ADD_IDX;
                            end
                            CMD_QUANT, CMD_SHORT: begin
                                r_prod  <= 64'({47'd0, in_ch.fraction} * {32'd0, r_cnt});
                                r_state <= ST_TGT;
                            end
                            CMD_CLEAR: begin
                                r_cnt      <= 32'd0;
                                r_clr_busy <= 1'b1;
                                r_clr_addr <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ADD_IDX: begin
                    r_idx   <= idx_c;
                    r_state <= ST_ADD_WR;
                end
                ST_ADD_WR: begin
                    if (r_cnt != 32'hFFFF_FFFF) begin
                        r_cnt <= r_cnt + 32'd1;
                    end
                    r_state <= ST_IDLE;
                end
                ST_TGT: begin
                    if (r_cnt == 32'd0) begin
                        r_res_price <= 32'd0;
                        r_res_bin   <= '0;
                        r_res_empty <= 1'b1;
                        r_state     <= ST_OUT;
                    end else begin
                        r_tgt   <= (tgt_c == 33'd0) ? TGT_W'(1) : TGT_W'(tgt_c);
                        r_b     <= '0;
                        r_oddw  <= {32'd0, cfg.bin_width};
                        r_cum   <= '0;
                        r_taken <= '0;
                        r_sum   <= 64'd0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_EV;
                end
                ST_EV: begin
                    if (r_is_sf) begin
                        r_take  <= take_c;
                        r_ctr   <= ctr_c;
                        r_state <= ST_MUL;
                    end else begin
                        r_cum <= cum_n;
                        if (cum_n >= CW'(r_tgt)) begin
                            r_res_price <= ctr_c;
                            r_res_bin   <= RES_BIN_W'(r_b);
                            r_res_empty <= 1'b0;
                            r_state     <= ST_OUT;
                        end else if (r_b == LAST_BIN) begin
                            r_res_price <= sat32({32'd0, cfg.range_low} + span);
                            r_res_bin   <= RES_BIN_W'(LAST_BIN);
                            r_res_empty <= 1'b0;
                            r_state     <= ST_OUT;
                        end else begin
                            r_b     <= r_b + 1'b1;
                            r_oddw  <= r_oddw + {31'd0, cfg.bin_width, 1'b0};
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod  <= {32'd0, r_take} * {32'd0, r_ctr};
                    r_taken <= r_taken + TGT_W'(r_take);
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_sum <= sum_n[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_n[63:0];
                    if ((r_taken >= r_tgt) || (r_b == LAST_BIN)) begin
                        r_res_empty <= 1'b0;
                        if (r_taken == '0) begin
                            r_res_price <= 32'd0;
                            r_res_bin   <= '0;
                            r_state     <= ST_OUT;
                        end else begin
                            r_res_bin   <= RES_BIN_W'((r_taken >= r_tgt) ? r_b : LAST_BIN);
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIV;
                        end
                    end else begin
                        r_b     <= r_b + 1'b1;
                        r_oddw  <= r_oddw + {31'd0, cfg.bin_width, 1'b0};
                        r_state <= ST_RD;
                    end
                end
                ST_DIV: begin
                    r_div_start <= 1'b0;
                    if (div_rsp.done) begin
                        r_res_price <= sat32(div_rsp.quot);
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_o_price <= r_res_price;
                        r_o_bin   <= r_res_bin;
                        r_o_empty <= r_res_empty;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign out_ch.valid        = r_ov;
    assign out_ch.result_price = r_o_price;
    assign out_ch.result_bin   = r_o_bin;
    assign out_ch.hist_empty   = r_o_empty;

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_ch.ready)
        else $error("word accepted during memory sweep");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE || r_clr_busy))
        else $error("sequencer idle right after accepting a word");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD_WR) |-> ($past(r_state) == ST_ADD_IDX))
        else $error("bin write back without a preceding read");

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");
endmodule

/* sim/tb.sv */
// Testbench for histogram_quantile_shortfall: random and directed commands,
// results checked against an in-bench histogram model, APB register phases.
// Depends on hqs_pkg, hqs_if and the block's RTL.
module tb;
    import hqs_pkg::*;

    localparam int NBINS = 8192;
    localparam int SWEEP_WAIT = NBINS + 400;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] price;
        logic [16:0] fraction;
    } t_word;

    typedef struct packed {
        logic [31:0] price;
        logic [12:0] bin;
        logic        empty;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    hqs_in_if in_ch();
    hqs_out_if out_ch();

    histogram_quantile_shortfall dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    logic [31:0] hist_bins [NBINS];
    logic [31:0] hist_total;
    logic [31:0] cfg_low, cfg_width, cfg_inv;
    t_word   words_to_send[$];
    t_result pending_results[$];
    int      mismatches = 0;
    int      idle_mode = 0;
    logic    in_fire = 1'b0;

    function automatic void queue_word(input t_word w);
        words_to_send.insert(words_to_send.size(), w);
    endfunction

    function automatic logic [12:0] bin_index(input logic [31:0] p);
        logic [63:0] off, idx;
        if (p <= cfg_low) return 13'd0;
        off = 64'(p - cfg_low);
        if (off >= 64'(NBINS) * 64'(cfg_width)) return 13'(NBINS - 1);
        idx = (off * 64'(cfg_inv)) >> 24;
        if (idx >= 64'(NBINS)) return 13'(NBINS - 1);
        return idx[12:0];
    endfunction

    function automatic logic [31:0] bin_center(input int b);
        logic [63:0] half;
        half = ((64'(b) * 2 + 1) * 64'(cfg_width)) >> 1;
        return sat32(64'(cfg_low) + half);
    endfunction

    function automatic logic [63:0] target_of(input logic [16:0] f);
        logic [63:0] t;
        t = (64'(f) * 64'(hist_total) + 64'd65535) >> 16;
        return (t < 1) ? 64'd1 : t;
    endfunction

    function automatic t_result quantile_of(input logic [16:0] f);
        t_result r;
        logic [63:0] tgt, cum;
        tgt = target_of(f);
        cum = 0;
        r.empty = 1'b0;
        for (int b = 0; b < NBINS; b++) begin
            cum += 64'(hist_bins[b]);
            if (cum >= tgt) begin
                r.price = bin_center(b);
                r.bin = 13'(b);
                return r;
            end
        end
        r.price = sat32(64'(cfg_low) + 64'(NBINS) * 64'(cfg_width));
        r.bin = 13'(NBINS - 1);
        return r;
    endfunction

    function automatic t_result shortfall_of(input logic [16:0] f);
        t_result r;
        logic [63:0] tgt, taken, take, prod;
        logic [64:0] sum;
        logic [12:0] hit;
        tgt = target_of(f);
        taken = 0;
        sum = 0;
        hit = 13'(NBINS - 1);
        for (int b = 0; b < NBINS && taken < tgt; b++) begin
            take = 64'(hist_bins[b]);
            if (take > tgt - taken) take = tgt - taken;
            prod = take * 64'(bin_center(b));
            sum = sum + 65'(prod);
            if (sum[64]) sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
            taken += take;
            if (taken >= tgt) hit = 13'(b);
        end
        r.empty = 1'b0;
        if (taken == 0) begin
            r.price = 0;
            r.bin = 0;
        end else begin
            r.price = sat32(sum[63:0] / taken);
            r.bin = hit;
        end
        return r;
    endfunction

    function automatic void apply_word(input t_word w);
        t_result r;
        logic [12:0] b;
        case (w.cmd)
            CMD_ADD: begin
                b = bin_index(w.price);
                if (hist_bins[b] != 32'hFFFF_FFFF) hist_bins[b]++;
                if (hist_total != 32'hFFFF_FFFF) hist_total++;
            end
            CMD_CLEAR: begin
                foreach (hist_bins[i]) hist_bins[i] = 0;
                hist_total = 0;
            end
            default: begin
                if (hist_total == 0) begin
                    r = '{price: 32'd0, bin: 13'd0, empty: 1'b1};
                end else if (w.cmd == CMD_QUANT) begin
                    r = quantile_of(w.fraction);
                end else begin
                    r = shortfall_of(w.fraction);
                end
                pending_results.insert(pending_results.size(), r);
            end
        endcase
    endfunction

    // Input driver; also drives the output ready.
    always @(negedge i_clk) begin
        if (!in_ch.valid || in_fire) begin
            if (words_to_send.size() > 0 &&
                !((idle_mode == 1 && $urandom_range(99) < 88) ||
                  (idle_mode == 3 && $urandom_range(99) < 25))) begin
                t_word w;
                w = words_to_send.pop_front();
                in_ch.cmd <= w.cmd;
                in_ch.sample_price <= w.price;
                in_ch.fraction <= w.fraction;
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= !((idle_mode == 2 && $urandom_range(99) < 88) ||
                          (idle_mode == 3 && $urandom_range(99) < 25));
    end

    // Monitor and checker.
    always @(posedge i_clk) begin
        in_fire <= in_ch.valid && in_ch.ready;
        if (in_ch.valid && in_ch.ready) begin
            apply_word('{cmd: in_ch.cmd, price: in_ch.sample_price,
                         fraction: in_ch.fraction});
        end
        if (out_ch.valid && out_ch.ready) begin
            t_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: price %h bin %0d empty %b",
                             out_ch.result_price, out_ch.result_bin, out_ch.hist_empty);
            end else begin
                want = pending_results.pop_front();
                if (want.price != out_ch.result_price || want.bin != out_ch.result_bin ||
                    want.empty != out_ch.hist_empty) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected price %h bin %0d empty %b, got %h %0d %b",
                                 want.price, want.bin, want.empty, out_ch.result_price,
                                 out_ch.result_bin, out_ch.hist_empty);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= CFG_AW'(idx) << 2;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_RANGE_LOW: cfg_low = val;
            REG_BIN_WIDTH: cfg_width = val;
            default: cfg_inv = val;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (words_to_send.size() > 0 || in_ch.valid || pending_results.size() > 0)
            @(posedge i_clk);
        repeat (SWEEP_WAIT) @(posedge i_clk);
    endtask

    function automatic t_word pick_word();
        t_word w;
        logic [63:0] v;
        int r;
        r = $urandom_range(99);
        w.fraction = 17'($urandom_range(0, 65536));
        if ($urandom_range(99) < 4) w.fraction = 17'($urandom_range(65537, 131071));
        w.price = $urandom;
        if (r < 82) begin
            w.cmd = CMD_ADD;
            r = $urandom_range(99);
            if (r < 85) begin
                v = 64'(cfg_low) + 64'($urandom_range(0, 150)) * 64'(cfg_width)
                    + 64'($urandom_range(0, 3)) * 64'(cfg_width >> 2);
                w.price = sat32(v);
            end else if (r < 92) begin
                w.price = cfg_low;
            end else if (r < 96) begin
                w.price = 32'hFFFF_FFFF;
            end
        end else if (r < 90) begin
            w.cmd = CMD_QUANT;
        end else if (r < 98) begin
            w.cmd = CMD_SHORT;
        end else begin
            w.cmd = CMD_CLEAR;
        end
        return w;
    endfunction

    initial begin
        logic [31:0] cfg_sets [5][3];
        cfg_sets = '{'{32'd25600, 32'd466, 32'd36002},
                     '{32'd0, 32'd1, 32'h0100_0000},
                     '{32'd1000, 32'd300, 32'd55924},
                     '{32'd0, 32'hFFFF_FFFF, 32'd1},
                     '{32'hFFFF_FFFF, 32'd16, 32'hFFFF_FFFF}};
        foreach (hist_bins[i]) hist_bins[i] = 0;
        hist_total = 0;
        cfg_low = 32'd25600;
        cfg_width = 32'd466;
        cfg_inv = 32'd36002;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_ADD;
        in_ch.sample_price = '0;
        in_ch.fraction = '0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corner cases: empty queries, range edges, fraction extremes.
        queue_word('{CMD_QUANT, 32'd0, 17'd32768});
        queue_word('{CMD_SHORT, 32'd0, 17'd65536});
        queue_word('{CMD_ADD, 32'd0, 17'd0});
        queue_word('{CMD_ADD, 32'd25600, 17'd0});
        queue_word('{CMD_ADD, 32'd25601, 17'd0});
        queue_word('{CMD_ADD, 32'd25600 + 32'd466 * 8192, 17'd0});
        queue_word('{CMD_ADD, 32'hFFFF_FFFF, 17'd0});
        queue_word('{CMD_ADD, 32'h5555_5555, 17'd0});
        queue_word('{CMD_ADD, 32'hAAAA_AAAA, 17'd0});
        queue_word('{CMD_QUANT, 32'd0, 17'd0});
        queue_word('{CMD_QUANT, 32'd0, 17'd65536});
        queue_word('{CMD_QUANT, 32'd0, 17'h1FFFF});
        queue_word('{CMD_SHORT, 32'd0, 17'd0});
        queue_word('{CMD_SHORT, 32'd0, 17'd32768});
        queue_word('{CMD_SHORT, 32'd0, 17'h1FFFF});
        queue_word('{CMD_CLEAR, 32'hFFFF_FFFF, 17'h1FFFF});
        queue_word('{CMD_QUANT, 32'd0, 17'd65536});
        queue_word('{CMD_SHORT, 32'd0, 17'd1});

        for (int p = 0; p < 5; p++) begin
            if (p > 0) begin
                wait_idle();
                for (int i = 0; i < 3; i++) write_reg(2'(i), cfg_sets[p][i]);
            end
            idle_mode = p % 4;
            for (int n = 0; n < 87; n++) queue_word(pick_word());
        end
        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #800000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
